// ----- rtl/frg_pkg.sv -----
// ----------------------------------------------------------------------------
// frg_pkg
// Shared widths and types for the fraction reduction block.
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int unsigned DataWidth = 32;
  // shift count of the common power of two (0 .. DataWidth-1)
  localparam int unsigned ShiftW    = $clog2(DataWidth);
  // divider step counter, holds DataWidth itself
  localparam int unsigned CntW      = $clog2(DataWidth + 1);

  typedef logic [DataWidth-1:0]        word_t;
  typedef logic signed [DataWidth-1:0] sword_t;
  typedef logic [DataWidth-2:0]        gcd_t;
  typedef logic [ShiftW-1:0]           shift_t;
  typedef logic [CntW-1:0]             cnt_t;

  function automatic word_t magnitude(input sword_t v);
    word_t m;
    m = word_t'(v);
    if (v[DataWidth-1]) begin
      m = ~m + word_t'(1);
    end
    return m;
  endfunction

  function automatic sword_t apply_sign(input word_t q, input logic neg);
    sword_t s;
    s = sword_t'(q);
    if (neg) begin
      s = sword_t'(~q + word_t'(1));
    end
    return s;
  endfunction

endpackage

// ----- rtl/frg_if.sv -----
// ----------------------------------------------------------------------------
// frg_in_if / frg_out_if
// Valid/ready channels for the fraction reduction block.
// ----------------------------------------------------------------------------
interface frg_in_if;
  logic           valid;
  logic           ready;
  frg_pkg::sword_t numerator;
  frg_pkg::sword_t denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frg_out_if;
  logic            valid;
  logic            ready;
  frg_pkg::sword_t reduced_numerator;
  frg_pkg::sword_t reduced_denominator;
  frg_pkg::gcd_t   common_divisor;
  logic            zero_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output common_divisor, output zero_denominator, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input common_divisor, input zero_denominator, output ready);
endinterface

// ----- rtl/frg_divider.sv -----
// ----------------------------------------------------------------------------
// frg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frg_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  frg_pkg::word_t dividend_i,
  input  frg_pkg::word_t divisor_i,
  output logic          done_o,
  output frg_pkg::word_t quotient_o
);

  frg_pkg::word_t rem_q, rem_d;
  frg_pkg::word_t quo_q, quo_d;
  frg_pkg::cnt_t  cnt_q, cnt_d;
  logic           done_q, done_d;

  logic [frg_pkg::DataWidth:0]   shifted;
  logic [frg_pkg::DataWidth+1:0] diff;

  assign shifted = {rem_q, quo_q[frg_pkg::DataWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = frg_pkg::cnt_t'(frg_pkg::DataWidth);
    end else if (cnt_q != '0) begin
      // borrow bit clear means the trial subtract fits
      if (!diff[frg_pkg::DataWidth+1]) begin
        rem_d = diff[frg_pkg::DataWidth-1:0];
      end else begin
        rem_d = shifted[frg_pkg::DataWidth-1:0];
      end
      quo_d  = {quo_q[frg_pkg::DataWidth-2:0], ~diff[frg_pkg::DataWidth+1]};
      cnt_d  = cnt_q - frg_pkg::cnt_t'(1);
      done_d = (cnt_q == frg_pkg::cnt_t'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/fraction_reduce_gcd_top.sv -----
// ----------------------------------------------------------------------------
// fraction_reduce_gcd_top
// Reduces a signed fraction by the gcd of its magnitudes (binary gcd, then two
// exact divisions on one shared restoring divider).
// ----------------------------------------------------------------------------
// Sequence: the binary gcd loop runs shift and subtract steps until one operand
//   is zero, the common factors of two are shifted back in, each division then
//   runs on the divider, and the result is loaded into the output register.
// Zero denominator: the gcd and divisions are skipped. One word at a time; ready
//   is low while busy and returns together with the output valid.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module fraction_reduce_gcd_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  frg_in_if.sink     in_i,
  frg_out_if.source  out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StGcd,
    StShift,
    StDivN,
    StDivD,
    StHold
  } state_e;

  state_e          state_q, state_d;
  frg_pkg::word_t  mag_n_q, mag_n_d;
  frg_pkg::word_t  mag_d_q, mag_d_d;
  logic            neg_n_q, neg_n_d;
  logic            neg_d_q, neg_d_d;
  frg_pkg::word_t  a_q, a_d;
  frg_pkg::word_t  b_q, b_d;
  frg_pkg::shift_t k_q, k_d;
  frg_pkg::word_t  qn_q, qn_d;
  logic            err_q, err_d;
  logic            start_q, start_d;

  logic            out_valid_q, out_valid_d;
  frg_pkg::sword_t res_n_q, res_n_d;
  frg_pkg::sword_t res_d_q, res_d_d;
  frg_pkg::gcd_t   res_g_q, res_g_d;
  logic            res_e_q, res_e_d;

  logic            div_done;
  frg_pkg::word_t  div_quo;
  frg_pkg::word_t  div_dividend;
  logic            slot_free;
  frg_pkg::word_t  in_mag_n, in_mag_d;

  assign in_mag_n     = frg_pkg::magnitude(in_i.numerator);
  assign in_mag_d     = frg_pkg::magnitude(in_i.denominator);
  assign div_dividend = (state_q == StDivN) ? mag_n_q : mag_d_q;
  assign slot_free    = !out_valid_q || out_o.ready;

  // a_q holds the gcd once the loop and the shift back end; divider divides by it
  frg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (div_dividend),
    .divisor_i  (a_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    mag_n_d     = mag_n_q;
    mag_d_d     = mag_d_q;
    neg_n_d     = neg_n_q;
    neg_d_d     = neg_d_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    qn_d        = qn_q;
    err_d       = err_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    res_n_d     = res_n_q;
    res_d_d     = res_d_q;
    res_g_d     = res_g_q;
    res_e_d     = res_e_q;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          mag_n_d = in_mag_n;
          mag_d_d = in_mag_d;
          neg_n_d = in_i.numerator[frg_pkg::DataWidth-1];
          neg_d_d = in_i.denominator[frg_pkg::DataWidth-1];
          a_d     = in_mag_n;
          b_d     = in_mag_d;
          k_d     = '0;
          qn_d    = '0;
          err_d   = (in_mag_d == '0);
          state_d = (in_mag_d == '0) ? StHold : StGcd;
        end
      end
      StGcd: begin
        if (a_q == '0 || b_q == '0) begin
          a_d = a_q | b_q;
          if (k_q == '0) begin
            start_d = 1'b1;
            state_d = StDivN;
          end else begin
            state_d = StShift;
          end
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + frg_pkg::shift_t'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      StShift: begin
        a_d = a_q << 1;
        k_d = k_q - frg_pkg::shift_t'(1);
        if (k_q == frg_pkg::shift_t'(1)) begin
          start_d = 1'b1;
          state_d = StDivN;
        end
      end
      StDivN: begin
        if (div_done) begin
          qn_d    = div_quo;
          start_d = 1'b1;
          state_d = StDivD;
        end
      end
      StDivD: begin
        if (div_done) begin
          b_d     = div_quo;
          state_d = StHold;
        end
      end
      StHold: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_e_d     = err_q;
          if (err_q) begin
            res_n_d = '0;
            res_d_d = '0;
            res_g_d = '0;
          end else begin
            res_n_d = frg_pkg::apply_sign(qn_q, neg_n_q);
            res_d_d = frg_pkg::apply_sign(b_q, neg_d_q);
            res_g_d = a_q[frg_pkg::DataWidth-2:0];
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_n_q <= mag_n_d;
    mag_d_q <= mag_d_d;
    neg_n_q <= neg_n_d;
    neg_d_q <= neg_d_d;
    a_q     <= a_d;
    b_q     <= b_d;
    k_q     <= k_d;
    qn_q    <= qn_d;
    err_q   <= err_d;
    res_n_q <= res_n_d;
    res_d_q <= res_d_d;
    res_g_q <= res_g_d;
    res_e_q <= res_e_d;
  end

  assign in_i.ready                = (state_q == StIdle);
  assign out_o.valid               = out_valid_q;
  assign out_o.reduced_numerator   = res_n_q;
  assign out_o.reduced_denominator = res_d_q;
  assign out_o.common_divisor      = res_g_q;
  assign out_o.zero_denominator    = res_e_q;

endmodule

// ----- rtl/frg_checker.sv -----
// ----------------------------------------------------------------------------
// frg_checker
// Port-level checks for the fraction reduction block.
// ----------------------------------------------------------------------------
module frg_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input frg_pkg::sword_t red_num_i,
  input frg_pkg::sword_t red_den_i,
  input frg_pkg::gcd_t   gcd_i,
  input logic            zero_den_i
);

  // stalled output holds valid, numerator and denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_num_i) && $stable(red_den_i))
    else $error("output word changed while stalled");

  // error result carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_den_i |-> red_num_i == '0 && red_den_i == '0 && gcd_i == '0)
    else $error("zero denominator result not cleared");

  // a zero numerator reduces to 0 over +1 or -1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !zero_den_i && red_num_i == '0 |->
      red_den_i == frg_pkg::sword_t'(1) || red_den_i == '1)
    else $error("zero numerator not reduced to unit denominator");

  // one word at a time: busy right after accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

endmodule

bind fraction_reduce_gcd_top frg_checker u_frg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_num_i   (out_o.reduced_numerator),
  .red_den_i   (out_o.reduced_denominator),
  .gcd_i       (out_o.common_divisor),
  .zero_den_i  (out_o.zero_denominator)
);

// ----- sim/tb_fraction_reduce_gcd_top.sv -----
// ----------------------------------------------------------------------------
// tb_fraction_reduce_gcd_top
// Sends signed fractions into the reduction block and checks every returned
// word against an in-bench gcd reduction. Directed corner cases come first,
// then constructed and random fractions over four flow-control phases.
// ----------------------------------------------------------------------------
module tb_fraction_reduce_gcd_top;

  localparam int unsigned     ClkPeriod     = 4;
  localparam int unsigned     TimeoutCycles = 600000;
  localparam int unsigned     ItemsPerPhase = 100;
  localparam int unsigned     NumDirected   = 24;
  localparam frg_pkg::sword_t MostNeg       = frg_pkg::sword_t'(32'h8000_0000);

  typedef struct packed {
    frg_pkg::sword_t num;
    frg_pkg::sword_t den;
    frg_pkg::gcd_t   div;
    logic            zero;
  } ratio_t;

  // numerator / denominator pairs for the directed part
  localparam frg_pkg::sword_t DirNum [NumDirected] = '{
    0, 0, 0, 0, 5, 0, -2147483647,
    2147483647, -2147483647, 2147483647, -2147483647,
    12, -12, 12, -12, 1, 1073741824,
    1836311903, -1134903170, 3145728,
    MostNeg, MostNeg, 0, MostNeg
  };
  localparam frg_pkg::sword_t DirDen [NumDirected] = '{
    1, -1, 2147483647, -2147483647, 0, 0, 0,
    2147483647, 2147483647, -2147483647, -2147483647,
    18, 18, -18, -18, 1, 536870912,
    1134903170, 1836311903, -167772160,
    MostNeg, 6, MostNeg, 0
  };

  class ratio_checker;
    ratio_t      expected_ratios[$];
    int unsigned mismatches;
    int unsigned results_seen;

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Euclid on the magnitudes, then exact division keeping each sign
    function ratio_t reduce_fraction(frg_pkg::sword_t n, frg_pkg::sword_t d);
      ratio_t         res;
      frg_pkg::word_t mag_n, mag_d, a, b, r, qn, qd;
      res   = '0;
      mag_n = n[frg_pkg::DataWidth-1] ? ~frg_pkg::word_t'(n) + frg_pkg::word_t'(1)
                                      : frg_pkg::word_t'(n);
      mag_d = d[frg_pkg::DataWidth-1] ? ~frg_pkg::word_t'(d) + frg_pkg::word_t'(1)
                                      : frg_pkg::word_t'(d);
      if (mag_d == '0) begin
        res.zero = 1'b1;
        return res;
      end
      a = mag_n;
      b = mag_d;
      r = a % b;
      while (r != '0) begin
        a = b;
        b = r;
        r = a % b;
      end
      qn = mag_n / b;
      qd = mag_d / b;
      res.num = n[frg_pkg::DataWidth-1] ? frg_pkg::sword_t'(frg_pkg::word_t'(0) - qn)
                                        : frg_pkg::sword_t'(qn);
      res.den = d[frg_pkg::DataWidth-1] ? frg_pkg::sword_t'(frg_pkg::word_t'(0) - qd)
                                        : frg_pkg::sword_t'(qd);
      // a gcd of 2^(W-1) drops its top bit here
      res.div = b[frg_pkg::DataWidth-2:0];
      return res;
    endfunction

    function void note_fraction(frg_pkg::sword_t n, frg_pkg::sword_t d);
      expected_ratios.push_back(reduce_fraction(n, d));
    endfunction

    task check_ratio(ratio_t got);
      ratio_t exp_r;
      results_seen++;
      if (expected_ratios.size() == 0) begin
        report($sformatf("word %0d arrived with no input pending", results_seen));
        return;
      end
      exp_r = expected_ratios.pop_front();
      if (got.num !== exp_r.num)
        report($sformatf("word %0d reduced_numerator got %0d exp %0d",
                         results_seen, got.num, exp_r.num));
      if (got.den !== exp_r.den)
        report($sformatf("word %0d reduced_denominator got %0d exp %0d",
                         results_seen, got.den, exp_r.den));
      if (got.div !== exp_r.div)
        report($sformatf("word %0d common_divisor got %0d exp %0d",
                         results_seen, got.div, exp_r.div));
      if (got.zero !== exp_r.zero)
        report($sformatf("word %0d zero_denominator got %0b exp %0b",
                         results_seen, got.zero, exp_r.zero));
    endtask

    function int unsigned pending();
      return expected_ratios.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  int unsigned  src_idle_pct;
  int unsigned  snk_stall_pct;
  ratio_checker ledger;

  frg_in_if  in_ch ();
  frg_out_if out_ch ();

  fraction_reduce_gcd_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // result checked before the input at the same edge is noted
  always @(posedge clk) begin
    ratio_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.num  = out_ch.reduced_numerator;
        seen.den  = out_ch.reduced_denominator;
        seen.div  = out_ch.common_divisor;
        seen.zero = out_ch.zero_denominator;
        ledger.check_ratio(seen);
      end
      if (in_ch.valid && in_ch.ready) begin
        ledger.note_fraction(in_ch.numerator, in_ch.denominator);
      end
    end
  end

  task automatic send_fraction(frg_pkg::sword_t n, frg_pkg::sword_t d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.numerator   <= n;
    in_ch.denominator <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // mostly pairs built on a shared factor so the gcd is nontrivial
  task automatic random_fraction(output frg_pkg::sword_t n, output frg_pkg::sword_t d);
    int unsigned  mode;
    int unsigned  gbits;
    int unsigned  mbits;
    logic [63:0]  g, mn, md;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      n = frg_pkg::sword_t'($urandom);
      d = frg_pkg::sword_t'($urandom);
      if (n == MostNeg) n = n + 1;
      if (d == MostNeg) d = d + 1;
    end else if (mode < 8) begin
      if (mode == 7) begin
        // odd core with a run of shared factors of two
        g = 64'($urandom_range(1, 255) | 1) << $urandom_range(0, 22);
      end else begin
        gbits = $urandom_range(1, 30);
        g = 64'($urandom) & ((64'd1 << gbits) - 64'd1);
        if (g == 64'd0) g = 64'd1;
      end
      gbits = 0;
      while ((g >> gbits) != 64'd0) gbits++;
      mbits = 31 - gbits;
      mn = 64'($urandom) & ((64'd1 << mbits) - 64'd1);
      md = 64'($urandom) & ((64'd1 << mbits) - 64'd1);
      n = frg_pkg::sword_t'(mn * g);
      d = frg_pkg::sword_t'(md * g);
      if ($urandom_range(0, 1) == 1) n = -n;
      if ($urandom_range(0, 1) == 1) d = -d;
    end else if (mode == 8) begin
      n = frg_pkg::sword_t'($urandom_range(0, 2147483647));
      d = frg_pkg::sword_t'($urandom_range(0, 2147483647));
      if ($urandom_range(0, 1) == 1) n = -n;
      if ($urandom_range(0, 1) == 1) d = -d;
      if ($urandom_range(0, 2) == 0) d = '0;
      else n = '0;
    end else begin
      n = frg_pkg::sword_t'($urandom_range(0, 40)) - 20;
      d = frg_pkg::sword_t'($urandom_range(0, 40)) - 20;
    end
  endtask

  initial begin
    frg_pkg::sword_t n, d;
    int unsigned     src_by_phase [4];
    int unsigned     snk_by_phase [4];
    src_by_phase = '{0, 61, 0, 27};
    snk_by_phase = '{0, 0, 61, 27};
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    ledger            = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.numerator   <= '0;
    in_ch.denominator <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) send_fraction(DirNum[i], DirDen[i]);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_by_phase[p];
      snk_stall_pct = snk_by_phase[p];
      for (int k = 0; k < ItemsPerPhase; k++) begin
        random_fraction(n, d);
        send_fraction(n, d);
      end
      // hold off until the block has drained
      in_ch.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clk);
      @(posedge clk);
    end

    repeat (250) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
